@@ rtl/drpm_pkg.sv @@
// Shared types, constants and helpers for the dual encoder rpm meter.
package drpm_pkg;

   localparam int COUNT_WIDTH = 16;            // edge counter width (8..32)
   localparam int TICK_W      = 16;            // window tick counter width
   localparam int WIN_W       = 16;            // window_ms register width
   localparam int PPR_W       = 13;            // pulses_per_rev register width
   localparam int CSR_DATA_W  = 16;            // widest register
   localparam int CSR_IDX_W   = 1;
   localparam int RPM_W       = 32;
   localparam int CNT_OUT_W   = 16;
   localparam int MSPM_W      = 16;            // width of the ms-per-minute constant
   localparam int NUM_W       = COUNT_WIDTH + MSPM_W;
   localparam int DEN_W       = WIN_W + PPR_W;
   localparam int DIV_CNT_W   = $clog2(NUM_W);
   localparam int SAT_W       = (NUM_W > RPM_W) ? NUM_W : RPM_W;  // rpm clamp compare width
   localparam int REQ_DATA_W  = 8;
   localparam int RSP_DATA_W  = 2 * RPM_W + 2 * CNT_OUT_W;

   localparam logic [MSPM_W-1:0] MS_PER_MINUTE = MSPM_W'(60000);
   localparam logic [WIN_W-1:0]  WINDOW_RESET  = WIN_W'(1000);
   localparam logic [PPR_W-1:0]  PPR_RESET     = PPR_W'(20);

   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_MS = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_PPR       = CSR_IDX_W'(1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic in_ready;   // take requests
      logic mul_en;     // form numerators and denominator
      logic div_step;   // one quotient bit per channel
      logic load_out;   // move quotients into the output register
   } cmd_type;

   typedef struct packed {
      logic close_hit;  // accepted request closed the window
      logic div_last;   // final divide step this cycle
      logic out_free;   // output register can take a new result
   } sts_type;

endpackage

@@ rtl/drpm_ctrl.sv @@
// Sequencer: sample, multiply, divide, deliver.
module drpm_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  drpm_pkg::sts_type sts,
   output drpm_pkg::cmd_type cmd
);
   import drpm_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (sts.close_hit) state_in = ST_MUL;
         end
         ST_MUL: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (sts.div_last) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (sts.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: cmd.in_ready = 1'b1;
         ST_MUL:  cmd.mul_en   = 1'b1;
         ST_DIV:  cmd.div_step = 1'b1;
         ST_DONE: cmd.load_out = sts.out_free;
         default: cmd = '0;
      endcase
   end

endmodule

@@ rtl/drpm_datapath.sv @@
// Edge counters, window timer, config registers, shared-denominator divider, output register.
module drpm_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   input  logic [drpm_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  logic                                 csr_we,
   input  logic [drpm_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [drpm_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  drpm_pkg::cmd_type                    cmd,
   output drpm_pkg::sts_type                    sts,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [drpm_pkg::RSP_DATA_W-1:0]      rsp_tdata
);
   import drpm_pkg::*;

   function automatic logic [RPM_W-1:0] sat_rpm(input logic [NUM_W-1:0] q);
      logic [SAT_W-1:0] ext;
      ext = SAT_W'(q);
      if (ext > SAT_W'({RPM_W{1'b1}})) sat_rpm = '1;
      else                            sat_rpm = ext[RPM_W-1:0];
   endfunction

   // config
   logic [WIN_W-1:0] window_ff;
   logic [PPR_W-1:0] ppr_ff;

   // sampling state
   logic                   prev_a_ff, prev_b_ff;
   logic [COUNT_WIDTH-1:0] edges_a_ff, edges_b_ff;
   logic [COUNT_WIDTH-1:0] edges_a_in, edges_b_in;
   logic [TICK_W-1:0]      ticks_ff, ticks_in;
   logic [COUNT_WIDTH-1:0] snap_a_ff, snap_b_ff;

   // divider
   logic [NUM_W-1:0]     quo_a_ff, quo_b_ff;
   logic [DEN_W-1:0]     rem_a_ff, rem_b_ff;
   logic [DEN_W-1:0]     den_ff;
   logic [DIV_CNT_W-1:0] div_cnt_ff;
   logic [DEN_W:0]       trial_a, trial_b;
   logic                 fit_a, fit_b;

   // output
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   logic             accept;
   logic             pin_a, pin_b, ms_tick;
   logic [WIN_W-1:0] win_eff;
   logic [PPR_W-1:0] ppr_eff;
   logic             close;

   assign accept  = req_tvalid & cmd.in_ready;
   assign pin_a   = req_tdata[0];
   assign pin_b   = req_tdata[1];
   assign ms_tick = req_tdata[2];
   assign win_eff = (window_ff == '0) ? WIN_W'(1) : window_ff;
   assign ppr_eff = (ppr_ff == '0) ? PPR_W'(1) : ppr_ff;

   always_comb begin
      edges_a_in = edges_a_ff;
      edges_b_in = edges_b_ff;
      ticks_in   = ticks_ff;
      if (prev_a_ff && !pin_a && (edges_a_ff != '1)) edges_a_in = edges_a_ff + 1'b1;
      if (prev_b_ff && !pin_b && (edges_b_ff != '1)) edges_b_in = edges_b_ff + 1'b1;
      if (ms_tick && (ticks_ff != '1))               ticks_in   = ticks_ff + 1'b1;
   end

   assign close = (ticks_in >= TICK_W'(win_eff));

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WINDOW_RESET;
         ppr_ff    <= PPR_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_WINDOW_MS: window_ff <= csr_wdata[WIN_W-1:0];
            CSR_PPR:       ppr_ff    <= csr_wdata[PPR_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_a_ff  <= 1'b1;
         prev_b_ff  <= 1'b1;
         edges_a_ff <= '0;
         edges_b_ff <= '0;
         ticks_ff   <= '0;
      end else if (accept) begin
         prev_a_ff <= pin_a;
         prev_b_ff <= pin_b;
         if (close) begin
            edges_a_ff <= '0;
            edges_b_ff <= '0;
            ticks_ff   <= '0;
         end else begin
            edges_a_ff <= edges_a_in;
            edges_b_ff <= edges_b_in;
            ticks_ff   <= ticks_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && close) begin
         snap_a_ff <= edges_a_in;
         snap_b_ff <= edges_b_in;
      end
   end

   // restoring divide, both channels against the same denominator
   assign trial_a = {rem_a_ff, quo_a_ff[NUM_W-1]};
   assign trial_b = {rem_b_ff, quo_b_ff[NUM_W-1]};
   assign fit_a   = (trial_a >= {1'b0, den_ff});
   assign fit_b   = (trial_b >= {1'b0, den_ff});

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         quo_a_ff   <= NUM_W'(snap_a_ff) * NUM_W'(MS_PER_MINUTE);
         quo_b_ff   <= NUM_W'(snap_b_ff) * NUM_W'(MS_PER_MINUTE);
         den_ff     <= DEN_W'(win_eff) * DEN_W'(ppr_eff);
         rem_a_ff   <= '0;
         rem_b_ff   <= '0;
         div_cnt_ff <= '0;
      end else if (cmd.div_step) begin
         quo_a_ff   <= {quo_a_ff[NUM_W-2:0], fit_a};
         quo_b_ff   <= {quo_b_ff[NUM_W-2:0], fit_b};
         rem_a_ff   <= fit_a ? DEN_W'(trial_a - {1'b0, den_ff}) : trial_a[DEN_W-1:0];
         rem_b_ff   <= fit_b ? DEN_W'(trial_b - {1'b0, den_ff}) : trial_b[DEN_W-1:0];
         div_cnt_ff <= div_cnt_ff + 1'b1;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // counts go out at 16 bits whatever the counter width
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_data_ff <= {CNT_OUT_W'(snap_b_ff), CNT_OUT_W'(snap_a_ff),
                         sat_rpm(quo_b_ff), sat_rpm(quo_a_ff)};
      end
   end

   assign rsp_tvalid    = rsp_valid_ff;
   assign rsp_tdata     = rsp_data_ff;
   assign sts.close_hit = accept & close;
   assign sts.div_last  = cmd.div_step & (div_cnt_ff == DIV_CNT_W'(NUM_W - 1));
   assign sts.out_free  = ~rsp_valid_ff | rsp_tready;

endmodule

@@ rtl/dual_encoder_rpm_meter_core.sv @@
// Top level of the two-channel windowed pulse-count tachometer.
//
// Usage:
//  - req channel: one request per clock while req_tready is high; each carries
//    the two encoder pin levels and a millisecond tick flag. Falling edges are
//    counted per channel (saturating), ticks advance the window timer.
//  - rsp channel: one response each time the window timer reaches window_ms,
//    with rpm = floor(60000 * edges / (window_ms * pulses_per_rev)) per channel
//    and the raw edge counts. The closing request's own edges count.
//  - csr port: csr_we writes csr_wdata to register csr_index
//    (0 = window_ms, 1 = pulses_per_rev) at the clock edge; zero acts as one.
// Throughput: one request per cycle while a window is open. The request that
//    closes a window starts a job: a multiply state forms the products, then a
//    restoring divider yields one quotient bit per cycle for both channels at
//    once, and a done state loads the result into the output register.
//    req_tready is low for that time.
// Stall: the response sits in an output register; if rsp_tready is low the
//    sequencer waits with the next result until that register is free.
// Reset (synchronous, active high): registers return to 1000 ms / 20 pulses,
//    counters clear, previous pin levels read as high, no response pending.
module dual_encoder_rpm_meter_core (
   input  logic                                 clock,
   input  logic                                 reset,
   // req_tdata: [0] pin_a, [1] pin_b, [2] ms_tick, rest zero
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [drpm_pkg::REQ_DATA_W-1:0]      req_tdata,
   // rsp_tdata: [31:0] rpm_a, [63:32] rpm_b, [79:64] count_a, [95:80] count_b
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [drpm_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  logic                                 csr_we,
   input  logic [drpm_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [drpm_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import drpm_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // sequencer: owns the request handshake and the divide schedule
   drpm_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .sts   (sts),
      .cmd   (cmd)
   );

   // counters, divider and output register
   drpm_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // requests are taken only while no window result is being computed
   assign req_tready = cmd.in_ready;

endmodule

@@ tb/sv/tb.sv @@
// Self-checking testbench for the dual encoder rpm meter core.
`timescale 1ns / 1ps

module tb;
   import drpm_pkg::*;

   // Run length guard for the whole simulation.
   localparam int  TIMEOUT_NS   = 10_000_000;
   // Drain length: covers the multiply, divide and done states of a window close; pad a little.
   localparam int  DRAIN_CYCLES = 2 + NUM_W + 8;
   // Receiver hold-off long enough to back the block up into req_tready.
   localparam int  LONG_HOLD    = 400;

   typedef enum int {
      IDLE_SEND_LIGHT,   // sender idles 20%, receiver 84%
      IDLE_SEND_HEAVY,   // sender idles 84%, receiver 20%
      IDLE_NONE
   } idle_mode_type;

   // One tachometer reading as it comes out on rsp_tdata.
   typedef struct {
      logic [RPM_W-1:0]     rpm_a;
      logic [RPM_W-1:0]     rpm_b;
      logic [CNT_OUT_W-1:0] count_a;
      logic [CNT_OUT_W-1:0] count_b;
   } reading_type;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   // req_tdata: [0] pin_a, [1] pin_b, [2] ms_tick, rest zero
   logic [REQ_DATA_W-1:0] req_tdata   = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   // rsp_tdata: [31:0] rpm_a, [63:32] rpm_b, [79:64] count_a, [95:80] count_b
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we      = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index   = '0;
   logic [CSR_DATA_W-1:0] csr_wdata   = '0;

   dual_encoder_rpm_meter_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Shadow tachometer: register copies and window state, updated on every
   // accepted request, producing the readings the core should emit.
   // ------------------------------------------------------------------
   logic [WIN_W-1:0]       shadow_window_ms  = WINDOW_RESET;
   logic [PPR_W-1:0]       shadow_ppr        = PPR_RESET;
   logic                   shadow_prev_a     = 1'b1;   // pins read high out of reset
   logic                   shadow_prev_b     = 1'b1;
   logic [COUNT_WIDTH-1:0] shadow_edges_a    = '0;
   logic [COUNT_WIDTH-1:0] shadow_edges_b    = '0;
   logic [TICK_W-1:0]      shadow_ticks      = '0;

   logic [REQ_DATA_W-1:0]  pending_requests[$];   // filled by the sequence below
   reading_type            expected_readings[$];  // oldest first

   idle_mode_type          idle_mode     = IDLE_SEND_LIGHT;
   int                     hold_requests = 0;     // bumped to ask for a long hold-off
   int                     hold_served   = 0;
   int                     hold_left     = 0;
   int                     mismatches    = 0;
   int                     n_requests    = 0;
   int                     n_readings    = 0;

   function automatic logic [RPM_W-1:0] rpm_for(logic [COUNT_WIDTH-1:0] edges,
                                                logic [WIN_W-1:0] win,
                                                logic [PPR_W-1:0] ppr);
      logic [63:0] quotient;
      quotient = (64'd60000 * 64'(edges)) / (64'(win) * 64'(ppr));
      return (quotient > 64'hFFFF_FFFF) ? '1 : quotient[RPM_W-1:0];
   endfunction

   // Order within a request: edges, then the tick, then the window check.
   task automatic tally_request(input logic [REQ_DATA_W-1:0] d);
      logic        pin_a;
      logic        pin_b;
      logic        tick;
      logic [WIN_W-1:0] win;
      logic [PPR_W-1:0] ppr;
      reading_type r;
      pin_a = d[0];
      pin_b = d[1];
      tick  = d[2];
      // zero in either register acts as one
      win   = (shadow_window_ms == '0) ? WIN_W'(1) : shadow_window_ms;
      ppr   = (shadow_ppr == '0) ? PPR_W'(1) : shadow_ppr;
      if (shadow_prev_a && !pin_a && shadow_edges_a != '1)
         shadow_edges_a = shadow_edges_a + 1'b1;
      if (shadow_prev_b && !pin_b && shadow_edges_b != '1)
         shadow_edges_b = shadow_edges_b + 1'b1;
      shadow_prev_a = pin_a;
      shadow_prev_b = pin_b;
      if (tick && shadow_ticks != '1)
         shadow_ticks = shadow_ticks + 1'b1;
      // >= so a window shortened below its tick count closes right away
      if (shadow_ticks >= TICK_W'(win)) begin
         r.rpm_a   = rpm_for(shadow_edges_a, win, ppr);
         r.rpm_b   = rpm_for(shadow_edges_b, win, ppr);
         r.count_a = CNT_OUT_W'(shadow_edges_a);
         r.count_b = CNT_OUT_W'(shadow_edges_b);
         expected_readings.push_back(r);
         shadow_edges_a = '0;
         shadow_edges_b = '0;
         shadow_ticks   = '0;
      end
   endtask

   function automatic int send_idle_pct(idle_mode_type m);
      case (m)
         IDLE_SEND_LIGHT: return 20;
         IDLE_SEND_HEAVY: return 84;
         default:         return 0;
      endcase
   endfunction

   function automatic int recv_idle_pct(idle_mode_type m);
      case (m)
         IDLE_SEND_LIGHT: return 84;
         IDLE_SEND_HEAVY: return 20;
         default:         return 0;
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Request driver: offers queued pin samples, idling at random per mode.
   // tvalid only drops after an accept, never while a request is on offer.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
      end else begin
         if (req_tvalid && req_tready) begin
            tally_request(req_tdata);
            n_requests++;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_requests.size() != 0 &&
                $urandom_range(99) >= send_idle_pct(idle_mode)) begin
               req_tdata  <= pending_requests.pop_front();
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Reading monitor: checks each accepted reading against the oldest
   // expectation and drives rsp_tready, including the long hold-off.
   // ------------------------------------------------------------------
   task automatic check_reading(input logic [RSP_DATA_W-1:0] d);
      reading_type want;
      reading_type got;
      got.rpm_a   = d[RPM_W-1:0];
      got.rpm_b   = d[2*RPM_W-1:RPM_W];
      got.count_a = d[2*RPM_W+CNT_OUT_W-1:2*RPM_W];
      got.count_b = d[2*RPM_W+2*CNT_OUT_W-1:2*RPM_W+CNT_OUT_W];
      if (expected_readings.size() == 0) begin
         $error("reading with none pending: rpm_a %0d rpm_b %0d count_a %0d count_b %0d",
                got.rpm_a, got.rpm_b, got.count_a, got.count_b);
         mismatches++;
      end else begin
         want = expected_readings.pop_front();
         if (got.rpm_a !== want.rpm_a) begin
            $error("rpm_a: expected %0d, got %0d", want.rpm_a, got.rpm_a);
            mismatches++;
         end
         if (got.rpm_b !== want.rpm_b) begin
            $error("rpm_b: expected %0d, got %0d", want.rpm_b, got.rpm_b);
            mismatches++;
         end
         if (got.count_a !== want.count_a) begin
            $error("count_a: expected %0d, got %0d", want.count_a, got.count_a);
            mismatches++;
         end
         if (got.count_b !== want.count_b) begin
            $error("count_b: expected %0d, got %0d", want.count_b, got.count_b);
            mismatches++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready  <= 1'b0;
         hold_left   <= 0;
         hold_served <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            check_reading(rsp_tdata);
            n_readings++;
         end
         if (hold_left != 0) begin
            rsp_tready <= 1'b0;
            hold_left  <= hold_left - 1;
         end else if (hold_served != hold_requests) begin
            rsp_tready  <= 1'b0;
            hold_left   <= LONG_HOLD;
            hold_served <= hold_requests;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct(idle_mode));
         end
      end
   end

   // ------------------------------------------------------------------
   // Sequence helpers. Queues and mode flags are touched on the falling
   // edge so the clocked processes above never race with them.
   // ------------------------------------------------------------------
   task automatic add_req(input logic pin_a, input logic pin_b, input logic tick);
      pending_requests.push_back({5'b0, tick, pin_b, pin_a});
   endtask

   task automatic add_random_reqs(input int n, input int tick_pct);
      for (int i = 0; i < n; i++)
         add_req(1'($urandom_range(1)), 1'($urandom_range(1)),
                 $urandom_range(99) < tick_pct);
   endtask

   // Idle: all requests taken, every reading back, divider given time to finish.
   task automatic wait_quiet();
      do
         @(negedge clock);
      while (pending_requests.size() != 0 || req_tvalid || expected_readings.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx == CSR_WINDOW_MS)
         shadow_window_ms = value[WIN_W-1:0];
      else if (idx == CSR_PPR)
         shadow_ppr = value[PPR_W-1:0];   // upper bits dropped by the core
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic random_phase(input idle_mode_type m, input int win, input int ppr,
                               input int tick_pct, input int n);
      wait_quiet();
      write_reg(CSR_WINDOW_MS, CSR_DATA_W'(win));
      write_reg(CSR_PPR, CSR_DATA_W'(ppr));
      @(negedge clock);
      idle_mode = m;
      add_random_reqs(n, tick_pct);
   endtask

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Reset registers (1000 ms, 20 ppr): the very first low samples count
      // as edges since the previous levels come out of reset high.
      @(negedge clock);
      idle_mode = IDLE_SEND_LIGHT;
      add_req(1'b0, 1'b0, 1'b0);
      add_req(1'b1, 1'b0, 1'b0);
      add_req(1'b0, 1'b1, 1'b0);
      add_req(1'b1, 1'b0, 1'b0);
      add_req(1'b1, 1'b1, 1'b1);
      add_random_reqs(999, 100);   // window closes on the 1000th tick
      add_req(1'b0, 1'b0, 1'b0);

      // One-tick window; edges in the closing request still count.
      wait_quiet();
      write_reg(CSR_WINDOW_MS, CSR_DATA_W'(1));
      write_reg(CSR_PPR, CSR_DATA_W'(1));
      @(negedge clock);
      add_req(1'b1, 1'b1, 1'b1);
      add_req(1'b0, 1'b0, 1'b1);
      add_req(1'b1, 1'b1, 1'b1);
      add_req(1'b0, 1'b1, 1'b1);
      add_req(1'b1, 1'b0, 1'b1);

      // Both registers zero: each acts as one.
      wait_quiet();
      write_reg(CSR_WINDOW_MS, '0);
      write_reg(CSR_PPR, '0);
      @(negedge clock);
      add_req(1'b0, 1'b0, 1'b1);
      add_req(1'b1, 1'b1, 1'b0);
      add_req(1'b0, 1'b1, 1'b1);

      // Longest window, ppr 4096; then shorten the window under the open
      // tick count so the next request closes it without a tick.
      wait_quiet();
      write_reg(CSR_WINDOW_MS, CSR_DATA_W'(65535));
      write_reg(CSR_PPR, CSR_DATA_W'(4096));
      @(negedge clock);
      add_req(1'b1, 1'b1, 1'b1);
      add_req(1'b0, 1'b0, 1'b0);
      add_req(1'b1, 1'b1, 1'b1);
      wait_quiet();
      write_reg(CSR_WINDOW_MS, CSR_DATA_W'(1));
      @(negedge clock);
      add_req(1'b0, 1'b0, 1'b0);

      // Random traffic across settings and idle patterns.
      random_phase(IDLE_SEND_LIGHT, 3, 20, 50, 100);
      random_phase(IDLE_SEND_LIGHT, 1, 1, 30, 100);
      random_phase(IDLE_SEND_LIGHT, 0, 0, 40, 80);
      random_phase(IDLE_SEND_HEAVY, 5, 4096, 80, 100);
      random_phase(IDLE_SEND_HEAVY, 16, 7, 90, 100);
      // all-ones write to ppr lands as 8191
      random_phase(IDLE_NONE, 2, 16'hFFFF, 60, 100);
      random_phase(IDLE_NONE, 65535, 3, 50, 100);
      // shrink the window well below the ticks already gathered
      wait_quiet();
      write_reg(CSR_WINDOW_MS, CSR_DATA_W'(4));
      @(negedge clock);
      add_random_reqs(100, 50);

      // Back-pressure: every request closes a window while the receiver
      // holds off, so the output register fills and req_tready stalls.
      random_phase(IDLE_NONE, 1, 1, 100, 150);
      hold_requests++;

      wait_quiet();
      $display("Covered %0d requests and %0d readings under three idle patterns.",
               n_requests, n_readings);
      $display("Windows 0..65535 ticks, ppr 0..8191, window shortening, output stall.");
      if (mismatches == 0 && expected_readings.size() == 0) begin
         $display("dual_encoder_rpm_meter_core: match");
      end else begin
         $display("dual_encoder_rpm_meter_core: mismatch");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("dual_encoder_rpm_meter_core: mismatch");
      $finish;
   end

endmodule
